// ===== rtl/core/ftlv_pkg.sv =====
// Shared types and constants of the fragmented TLV message deframer.
`default_nettype none

package ftlv_pkg;

  localparam int unsigned DEFAULT_LENGTH_WIDTH = 32;
  // Width of the total + fragment length + header sum; LENGTH_WIDTH must not exceed 32, which nothing enforces.
  localparam int unsigned LEN_SUM_W = 34;

  localparam logic [7:0] TERM_BYTE        = 8'hFF;
  localparam logic [32:0] CHUNK_HEAD_BYTES = 33'd5;
  localparam logic [32:0] HEADER_BYTES     = 33'd8;

  // Byte positions inside a fragment header.
  localparam logic [2:0] HDR_VERSION = 3'd0;
  localparam logic [2:0] HDR_TAG     = 3'd1;
  localparam logic [2:0] HDR_PRIO    = 3'd2;
  localparam logic [2:0] HDR_FLAG    = 3'd3;
  localparam logic [2:0] HDR_LAST    = 3'd7;

  localparam logic [1:0] LEN_LAST = 2'd3;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_TAG    = 3'd1,
    KIND_LENGTH = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_TERM   = 3'd4,
    KIND_ERROR  = 3'd5
  } byte_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_WRAP      = 3'd1,
    ERR_VERSION   = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_OVERRUN   = 3'd4,
    ERR_BAD_TERM  = 3'd5
  } error_e;

  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_TERM = 4'b1000
  } chunk_phase_e;

  typedef struct packed {
    byte_kind_e  kind;
    logic [7:0]  out_byte;
    logic [7:0]  chunk_tag;
    logic [31:0] chunk_length;
    logic [7:0]  message_tag;
    logic [7:0]  message_priority;
    logic        last_of_chunk;
    logic        message_done;
    error_e      error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ftlv_parser.sv =====
// Parser state and per-byte decode of the fragment headers and chunks.
`default_nettype none

module ftlv_parser #(
  parameter int unsigned LengthWidth = ftlv_pkg::DEFAULT_LENGTH_WIDTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic [7:0]      expected_version_i,
  output ftlv_pkg::result_t    result_o
);
  import ftlv_pkg::*;

  logic                   payload_q, payload_d;
  chunk_phase_e           phase_q, phase_d;
  logic [2:0]             hdr_cnt_q, hdr_cnt_d;
  logic [7:0]             version_q, version_d;
  logic                   flag_q, flag_d;
  logic [23:0]            len_hi_q, len_hi_d;
  logic [31:0]            frag_rem_q, frag_rem_d;
  logic [LengthWidth-1:0] total_q, total_d;
  logic                   more_q, more_d;
  logic [7:0]             msg_tag_q, msg_tag_d;
  logic [7:0]             msg_prio_q, msg_prio_d;
  logic [7:0]             ctag_q, ctag_d;
  logic [1:0]             lbc_q, lbc_d;
  logic [31:0]            acc_q, acc_d;
  logic [31:0]            cdr_q, cdr_d;

  logic [31:0]          dlen;
  logic [LEN_SUM_W-1:0] sum_base;
  logic [LEN_SUM_W-1:0] sum_hdr;
  logic                 wrap;
  logic                 final_frag;
  logic [32:0]          need;
  logic [31:0]          acc_n;
  logic [31:0]          rem_n;
  chunk_phase_e         phase_n;
  logic                 fail;
  error_e               fail_code;
  result_t              res;

  assign dlen     = {len_hi_q, data_byte_i};
  assign sum_base = LEN_SUM_W'(total_q) + LEN_SUM_W'(dlen);
  assign sum_hdr  = sum_base + LEN_SUM_W'(HEADER_BYTES);
  assign wrap     = |sum_hdr[LEN_SUM_W-1:LengthWidth];
  assign final_frag = !more_q;
  assign acc_n    = {acc_q[23:0], data_byte_i};
  assign rem_n    = frag_rem_q - 32'd1;

  // Bytes the chunk head or rest still needs, counting this byte.
  always_comb begin
    unique case (phase_q)
      PH_TAG:  need = CHUNK_HEAD_BYTES;
      PH_LEN:  need = 33'd4 - 33'(lbc_q);
      PH_DATA: need = 33'(cdr_q) + 33'd1;
      default: need = 33'd1;
    endcase
  end

  always_comb begin
    payload_d  = payload_q;
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    version_d  = version_q;
    flag_d     = flag_q;
    len_hi_d   = len_hi_q;
    frag_rem_d = frag_rem_q;
    total_d    = total_q;
    more_d     = more_q;
    msg_tag_d  = msg_tag_q;
    msg_prio_d = msg_prio_q;
    ctag_d     = ctag_q;
    lbc_d      = lbc_q;
    acc_d      = acc_q;
    cdr_d      = cdr_q;
    phase_n    = phase_q;
    fail       = 1'b0;
    fail_code  = ERR_NONE;
    res        = '0;
    res.kind   = KIND_HEADER;

    if (!payload_q) begin
      if (hdr_cnt_q == HDR_VERSION) version_d = data_byte_i;
      if (hdr_cnt_q == HDR_TAG && total_q == '0) msg_tag_d = data_byte_i;
      if (hdr_cnt_q == HDR_PRIO && total_q == '0) msg_prio_d = data_byte_i;
      if (hdr_cnt_q == HDR_FLAG) flag_d = (data_byte_i != 8'd0);
      if (hdr_cnt_q > HDR_FLAG && hdr_cnt_q != HDR_LAST) begin
        len_hi_d = {len_hi_q[15:0], data_byte_i};
      end
      if (hdr_cnt_q != HDR_LAST) begin
        hdr_cnt_d = hdr_cnt_q + 3'd1;
      end else begin
        hdr_cnt_d = '0;
        if (wrap) begin
          fail      = 1'b1;
          fail_code = ERR_WRAP;
        end else if (version_q != expected_version_i) begin
          fail      = 1'b1;
          fail_code = ERR_VERSION;
        end else begin
          total_d    = sum_base[LengthWidth-1:0];
          more_d     = flag_q;
          frag_rem_d = dlen;
          if (dlen != 32'd0) begin
            payload_d = 1'b1;
          end else if (!flag_q) begin
            // An empty final fragment must not leave a chunk open.
            if (phase_q == PH_LEN) begin
              fail      = 1'b1;
              fail_code = ERR_TRUNCATED;
            end else if (phase_q != PH_TAG) begin
              fail      = 1'b1;
              fail_code = ERR_OVERRUN;
            end else begin
              res.message_done = 1'b1;
              total_d          = '0;
              phase_d          = PH_TAG;
            end
          end
        end
      end
    end else begin
      if (final_frag && need > 33'(frag_rem_q)) begin
        fail      = 1'b1;
        fail_code = (phase_q == PH_TAG || phase_q == PH_LEN) ? ERR_TRUNCATED : ERR_OVERRUN;
      end else begin
        unique case (phase_q)
          PH_TAG: begin
            ctag_d   = data_byte_i;
            lbc_d    = '0;
            acc_d    = '0;
            phase_n  = PH_LEN;
            res.kind = KIND_TAG;
          end
          PH_LEN: begin
            acc_d    = acc_n;
            lbc_d    = lbc_q + 2'd1;
            res.kind = KIND_LENGTH;
            if (lbc_q == LEN_LAST) begin
              if (final_frag && (33'(acc_n) + 33'd1) > 33'(rem_n)) begin
                fail      = 1'b1;
                fail_code = ERR_OVERRUN;
              end else begin
                cdr_d            = acc_n;
                phase_n          = (acc_n != 32'd0) ? PH_DATA : PH_TERM;
                res.chunk_length = acc_n;
              end
            end
          end
          PH_DATA: begin
            cdr_d = cdr_q - 32'd1;
            if (cdr_q == 32'd1) phase_n = PH_TERM;
            res.kind         = KIND_DATA;
            res.chunk_length = acc_q;
          end
          default: begin
            if (data_byte_i != TERM_BYTE) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_TERM;
            end else begin
              res.last_of_chunk = 1'b1;
              res.kind          = KIND_TERM;
              res.chunk_length  = acc_q;
              phase_n           = PH_TAG;
            end
          end
        endcase
      end
      if (!fail) begin
        res.chunk_tag = ctag_d;
        frag_rem_d    = rem_n;
        if (rem_n != 32'd0) begin
          phase_d = phase_n;
        end else if (!final_frag) begin
          phase_d   = phase_n;
          payload_d = 1'b0;
        end else begin
          res.message_done = 1'b1;
          total_d          = '0;
          more_d           = 1'b0;
          payload_d        = 1'b0;
          phase_d          = PH_TAG;
        end
      end
    end

    res.out_byte         = data_byte_i;
    res.message_tag      = msg_tag_d;
    res.message_priority = msg_prio_d;

    // Any error drops the whole parse and waits for a fresh header.
    if (fail) begin
      res            = '0;
      res.kind       = KIND_ERROR;
      res.out_byte   = data_byte_i;
      res.error_code = fail_code;
      payload_d  = 1'b0;
      phase_d    = PH_TAG;
      hdr_cnt_d  = '0;
      version_d  = '0;
      flag_d     = 1'b0;
      len_hi_d   = '0;
      frag_rem_d = '0;
      total_d    = '0;
      more_d     = 1'b0;
      msg_tag_d  = '0;
      msg_prio_d = '0;
      ctag_d     = '0;
      lbc_d      = '0;
      acc_d      = '0;
      cdr_d      = '0;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q  <= 1'b0;
      phase_q    <= PH_TAG;
      hdr_cnt_q  <= '0;
      version_q  <= '0;
      flag_q     <= 1'b0;
      len_hi_q   <= '0;
      frag_rem_q <= '0;
      total_q    <= '0;
      more_q     <= 1'b0;
      msg_tag_q  <= '0;
      msg_prio_q <= '0;
      ctag_q     <= '0;
      lbc_q      <= '0;
      acc_q      <= '0;
      cdr_q      <= '0;
    end else if (step_i) begin
      payload_q  <= payload_d;
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      version_q  <= version_d;
      flag_q     <= flag_d;
      len_hi_q   <= len_hi_d;
      frag_rem_q <= frag_rem_d;
      total_q    <= total_d;
      more_q     <= more_d;
      msg_tag_q  <= msg_tag_d;
      msg_prio_q <= msg_prio_d;
      ctag_q     <= ctag_d;
      lbc_q      <= lbc_d;
      acc_q      <= acc_d;
      cdr_q      <= cdr_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fragmented_tlv_message_deframer.sv =====
// Top level of the fragmented TLV message deframer: handshakes, register, result stage.
//
// Bytes of the received stream enter on the input channel (in_valid_i / in_ready_o,
// data_byte_i), one byte per transfer. Every accepted byte yields exactly one result
// on the output channel (out_valid_o / out_ready_i): its kind, the byte itself, the
// current chunk tag and length, the message tag and priority, chunk and message end
// flags, and an error code. The expected header version is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is idle, which
// the block itself does not enforce. The result of a byte is registered and shows in
// the cycle after the byte is accepted. The block takes one byte per cycle while the
// receiver does not stall; the parser state and the result register both update in the
// accepting cycle. When the receiver stalls, the result register holds and in_ready_o
// drops until the waiting result is transferred; a byte is taken in the same cycle that
// the old result leaves. Reset clears the parse state (a new header is expected), the
// version register and the output valid flag, not the result register. After any error
// the block drops the partial message and expects a new fragment header.
`default_nettype none

module fragmented_tlv_message_deframer #(
  parameter int unsigned LENGTH_WIDTH = ftlv_pkg::DEFAULT_LENGTH_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       byte_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [7:0]       chunk_tag_o,
  output logic [31:0]      chunk_length_o,
  output logic [7:0]       message_tag_o,
  output logic [7:0]       message_priority_o,
  output logic             last_of_chunk_o,
  output logic             message_done_o,
  output logic [2:0]       error_code_o
);
  import ftlv_pkg::*;

  logic       [7:0] exp_version_q;
  logic             out_valid_q;
  result_t          res_q;
  result_t          res_d;
  logic             step;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  ftlv_parser #(
    .LengthWidth(LENGTH_WIDTH)
  ) u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .data_byte_i       (data_byte_i),
    .expected_version_i(exp_version_q),
    .result_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= '0;
    end else if (cfg_we_i) begin
      exp_version_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign byte_kind_o        = res_q.kind;
  assign out_byte_o         = res_q.out_byte;
  assign chunk_tag_o        = res_q.chunk_tag;
  assign chunk_length_o     = res_q.chunk_length;
  assign message_tag_o      = res_q.message_tag;
  assign message_priority_o = res_q.message_priority;
  assign last_of_chunk_o    = res_q.last_of_chunk;
  assign message_done_o     = res_q.message_done;
  assign error_code_o       = res_q.error_code;

  // Error results carry an error code and the byte itself, nothing of the parse.
  a_error_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_q.kind == KIND_ERROR |->
      res_q.error_code != ERR_NONE && res_q.message_tag == 8'd0 &&
      res_q.chunk_length == 32'd0 && !res_q.message_done)
    else $error("error result carries parse fields");

  a_code_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_q.error_code != ERR_NONE |-> res_q.kind == KIND_ERROR)
    else $error("error code without error kind");

  a_last_term : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_q.last_of_chunk |->
      res_q.kind == KIND_TERM && res_q.out_byte == TERM_BYTE)
    else $error("chunk end flagged on a byte that is not a good terminator");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted byte produced no result");

endmodule

`default_nettype wire
